@@ hdl/wsd_pkg.sv @@
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; every other file of the block imports this package.
package wsd_pkg;

  // Width of the payload length counter; extended lengths saturate to its range.
  localparam int unsigned LengthBits = 64;

  // Frame opcodes of interest.
  localparam logic [3:0] OpCont  = 4'h0;
  localparam logic [3:0] OpText  = 4'h1;
  localparam logic [3:0] OpBin   = 4'h2;
  localparam logic [3:0] OpClose = 4'h8;
  localparam logic [3:0] OpPing  = 4'h9;

  // Seven-bit length codes that announce an extended length.
  localparam logic [6:0] Len7Ext16 = 7'd126;
  localparam logic [6:0] Len7Ext64 = 7'd127;

  // Extended length and mask key sizes in bytes.
  localparam logic [3:0] Ext16Bytes = 4'd2;
  localparam logic [3:0] Ext64Bytes = 4'd8;
  localparam logic [3:0] MaskBytes  = 4'd4;

  typedef enum logic [2:0] {
    KindText    = 3'd0,
    KindFrag    = 3'd1,
    KindAbandon = 3'd2,
    KindPong    = 3'd3,
    KindClose   = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       has_byte;
    logic       end_of_run;
  } wsd_result_t;

endpackage

@@ hdl/wsd_if.sv @@
// Valid/ready channels of the deframer: received bytes in, results out.
// Depends on wsd_pkg for the result kind type.
interface wsd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wsd_res_if import wsd_pkg::*; ;
  logic       valid;
  logic       ready;
  kind_e      out_kind;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       end_of_run;

  modport source (output valid, output out_kind, output out_byte, output has_byte,
                  output end_of_run, input ready);
  modport sink   (input valid, input out_kind, input out_byte, input has_byte,
                  input end_of_run, output ready);
endinterface

@@ hdl/websocket_frame_deframer.sv @@
// Receive-side WebSocket frame deframer. It takes one received byte per beat on
// rx_i and returns at most one result per byte on res_o: text payload of single
// frame messages (kind 0), fragmented text payload (kind 1), an abandon event
// when a new fragmented text or binary frame replaces an open text fragment
// (kind 2), ping payload for a pong reply (kind 3) and a close event (kind 4).
// Payload bytes come out unmasked; end_of_run marks the last byte of a message
// or ping payload and every event but abandon. Empty frames that end a message,
// ping or close end on their last header byte with a byte-less end result.
// Pong, binary and unknown opcodes give no result but abandon. Throughput is
// one byte per cycle: the whole header or payload step for a byte is done in
// the cycle it is accepted, and its result sits in the output register from
// the next cycle on. That single output register sets the stall behavior: rx_i
// stays ready while it is empty or being drained, and drops only while a held
// result waits on a stalled res_o. Depends on wsd_pkg, wsd_if and wsd_parser.
module websocket_frame_deframer import wsd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  wsd_rx_if.sink rx_i,
  wsd_res_if.source res_o
);

  logic        beat;
  logic        res_valid;
  wsd_result_t res;
  logic        out_valid_q;
  wsd_result_t out_q;

  // Take a new byte whenever the output register is free or drains this cycle.
  assign rx_i.ready = !out_valid_q || res_o.ready;
  assign beat       = rx_i.valid && rx_i.ready;

  wsd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (beat),
    .rx_byte_i   (rx_i.rx_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Output register: load a new result, or drop the held one once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (beat) begin
      out_valid_q <= res_valid;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Payload needs no reset; it is only looked at while valid.
  always_ff @(posedge clk_i) begin
    if (beat && res_valid) begin
      out_q <= res;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.out_kind   = out_q.kind;
  assign res_o.out_byte   = out_q.data;
  assign res_o.has_byte   = out_q.has_byte;
  assign res_o.end_of_run = out_q.end_of_run;

`ifndef SYNTHESIS
  // A held result that is not taken must block the input side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.ready |-> !rx_i.ready)
    else $error("input accepted while a result is stalled");

  // A result without a payload byte carries a zero byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.has_byte |-> res_o.out_byte == 8'h00)
    else $error("byte-less result with nonzero byte");

  // Abandon is a bare event with no end marker.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.out_kind == KindAbandon |-> !res_o.has_byte && !res_o.end_of_run)
    else $error("malformed abandon event");

  // Close never carries payload and always ends its run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.out_kind == KindClose |-> !res_o.has_byte && res_o.end_of_run)
    else $error("malformed close event");
`endif

endmodule

@@ hdl/wsd_parser.sv @@
// Frame header parser and payload unmasker: holds the parse state and
// produces at most one result per accepted byte. Depends on wsd_pkg.
module wsd_parser import wsd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        beat_i,
  input  logic [7:0]  rx_byte_i,
  output logic        res_valid_o,
  output wsd_result_t res_o
);

  typedef enum logic [2:0] {
    PhHdr0    = 3'd0,
    PhHdr1    = 3'd1,
    PhExtLen  = 3'd2,
    PhMask    = 3'd3,
    PhPayload = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    FragNone = 2'd0,
    FragText = 2'd1,
    FragBin  = 2'd2
  } frag_e;

  localparam logic [LengthBits-1:0] LenOne = {{(LengthBits-1){1'b0}}, 1'b1};

  phase_e                phase_q, phase_d;
  logic                  fin_q, fin_d;
  logic [3:0]            opc_q, opc_d;
  logic                  masked_q, masked_d;
  logic [3:0]            hbl_q, hbl_d;
  logic [LengthBits-1:0] pay_q, pay_d;
  logic [31:0]           key_q, key_d;
  logic [1:0]            pos_q, pos_d;
  frag_e                 frag_q, frag_d;

  logic       after_len, hdr_done, act_en, act_have, act_last;
  logic       streams, run_end;
  kind_e      act_kind;
  logic [7:0] act_byte, key_byte;

  always_comb begin
    case (pos_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  always_comb begin
    phase_d     = phase_q;
    fin_d       = fin_q;
    opc_d       = opc_q;
    masked_d    = masked_q;
    hbl_d       = hbl_q;
    pay_d       = pay_q;
    key_d       = key_q;
    pos_d       = pos_q;
    frag_d      = frag_q;
    after_len   = 1'b0;
    hdr_done    = 1'b0;
    act_en      = 1'b0;
    act_have    = 1'b0;
    act_last    = 1'b0;
    act_byte    = 8'h00;
    act_kind    = KindText;
    streams     = 1'b0;
    run_end     = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;

    case (phase_q)
      PhHdr1: begin
        masked_d = rx_byte_i[7];
        pay_d    = '0;
        if (rx_byte_i[6:0] == Len7Ext16) begin
          phase_d = PhExtLen;
          hbl_d   = Ext16Bytes;
        end else if (rx_byte_i[6:0] == Len7Ext64) begin
          phase_d = PhExtLen;
          hbl_d   = Ext64Bytes;
        end else begin
          pay_d     = {{(LengthBits-7){1'b0}}, rx_byte_i[6:0]};
          after_len = 1'b1;
        end
      end
      PhExtLen: begin
        // Saturate once the length would overflow the counter.
        if (|pay_q[LengthBits-1 -: 8]) begin
          pay_d = '1;
        end else begin
          pay_d = {pay_q[LengthBits-9:0], rx_byte_i};
        end
        hbl_d = hbl_q - 4'd1;
        if (hbl_q == 4'd1) begin
          after_len = 1'b1;
        end
      end
      PhMask: begin
        key_d = {key_q[23:0], rx_byte_i};
        hbl_d = hbl_q - 4'd1;
        if (hbl_q == 4'd1) begin
          hdr_done = 1'b1;
        end
      end
      PhPayload: begin
        act_last = (pay_q <= LenOne);
        act_byte = masked_q ? (rx_byte_i ^ key_byte) : rx_byte_i;
        pos_d    = pos_q + 2'd1;
        if (pay_q != '0) begin
          pay_d = pay_q - LenOne;
        end
        if (act_last) begin
          phase_d = PhHdr0;
        end
        act_en   = 1'b1;
        act_have = 1'b1;
      end
      default: begin
        fin_d   = rx_byte_i[7];
        opc_d   = rx_byte_i[3:0];
        phase_d = PhHdr1;
      end
    endcase

    if (after_len) begin
      if (masked_d) begin
        phase_d = PhMask;
        hbl_d   = MaskBytes;
        key_d   = '0;
      end else begin
        hdr_done = 1'b1;
      end
    end

    if (hdr_done) begin
      pos_d = 2'd0;
      if (!fin_q && (opc_q == OpText || opc_q == OpBin)) begin
        if (frag_q == FragText) begin
          res_valid_o  = 1'b1;
          res_o.kind   = KindAbandon;
        end
        frag_d = (opc_q == OpText) ? FragText : FragBin;
      end
      if (pay_d == '0) begin
        phase_d = PhHdr0;
        if (!res_valid_o) begin
          act_en   = 1'b1;
          act_last = 1'b1;
        end
      end else begin
        phase_d = PhPayload;
      end
    end

    if (act_en) begin
      case (opc_q)
        OpText: begin
          act_kind = fin_q ? KindText : KindFrag;
          streams  = 1'b1;
          run_end  = act_last && fin_q;
        end
        OpCont: begin
          act_kind = KindFrag;
          streams  = (frag_q == FragText);
          run_end  = act_last && fin_q && streams;
          if (act_last && fin_q) begin
            frag_d = FragNone;
          end
        end
        OpPing: begin
          act_kind = KindPong;
          streams  = 1'b1;
          run_end  = act_last;
        end
        OpClose: begin
          act_kind = KindClose;
          run_end  = act_last;
        end
        default: begin
          streams = 1'b0;
        end
      endcase
      if (streams && act_have) begin
        res_valid_o      = 1'b1;
        res_o.kind       = act_kind;
        res_o.data       = act_byte;
        res_o.has_byte   = 1'b1;
        res_o.end_of_run = run_end;
      end else if (run_end) begin
        res_valid_o      = 1'b1;
        res_o.kind       = act_kind;
        res_o.end_of_run = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHdr0;
      fin_q    <= 1'b0;
      opc_q    <= 4'h0;
      masked_q <= 1'b0;
      hbl_q    <= 4'd0;
      pay_q    <= '0;
      key_q    <= '0;
      pos_q    <= 2'd0;
      frag_q   <= FragNone;
    end else if (beat_i) begin
      phase_q  <= phase_d;
      fin_q    <= fin_d;
      opc_q    <= opc_d;
      masked_q <= masked_d;
      hbl_q    <= hbl_d;
      pay_q    <= pay_d;
      key_q    <= key_d;
      pos_q    <= pos_d;
      frag_q   <= frag_d;
    end
  end

endmodule

@@ bench/tb_websocket_frame_deframer.sv @@
// Self-checking bench for websocket_frame_deframer: builds frame byte streams,
// predicts every result in a scoreboard class and checks the result channel.
// Depends on wsd_pkg, wsd_if and the deframer RTL.
`timescale 1ns / 100ps

module tb_websocket_frame_deframer;
  import wsd_pkg::*;

  localparam time         ClkPeriod      = 4ns;
  localparam int unsigned ResetCycles    = 7;
  localparam int unsigned RandomBytes    = 60;
  localparam int unsigned BatchBytes     = 80;
  localparam int unsigned TailBytes      = 24;
  localparam int unsigned LongHoldCycles = 120;
  localparam int unsigned DrainCycles    = 16;
  localparam int unsigned TimeoutCycles  = 300000;
  localparam int unsigned MaxReports     = 10;

  // Pong opcode: only the stimulus needs it, the block drops it.
  localparam logic [3:0] OpPong = 4'hA;

  // Largest length the block can hold; extended lengths above it saturate.
  localparam logic [63:0] LenMax = {64{1'b1}} >> (64 - LengthBits);

  // Parser phases, fragment states and length encodings used by the bench.
  typedef enum logic [2:0] {
    PhFirst   = 3'd0,
    PhSecond  = 3'd1,
    PhExtLen  = 3'd2,
    PhKey     = 3'd3,
    PhPayload = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    FragNone = 2'd0,
    FragText = 2'd1,
    FragBin  = 2'd2
  } frag_e;

  typedef enum int unsigned {
    FormShort,
    Form16,
    Form64
  } len_form_e;

  typedef enum int unsigned {
    SinkOpen,
    SinkCoin,
    SinkRare,
    SinkEveryFourth
  } sink_mode_e;

  // Tracks the frame parser state byte by byte and keeps the results that the
  // received bytes must produce, oldest first.
  class wsd_scoreboard;
    phase_e      phase;
    logic        fin;
    logic [3:0]  opcode;
    logic        masked;
    logic [3:0]  hdr_left;
    logic [63:0] pay_left;
    logic [31:0] key;
    logic [1:0]  key_pos;
    frag_e       frag;

    wsd_result_t expected_q[$];
    int unsigned bytes_seen;
    int unsigned results_seen;
    int unsigned mismatches;
    int unsigned kind_seen[5];

    function new();
      phase    = PhFirst;
      fin      = 1'b0;
      opcode   = OpCont;
      masked   = 1'b0;
      hdr_left = '0;
      pay_left = '0;
      key      = '0;
      key_pos  = '0;
      frag     = FragNone;
    endfunction

    function void push_result(kind_e k, logic [7:0] d, logic hb, logic eor);
      wsd_result_t r;
      r.kind       = k;
      r.data       = d;
      r.has_byte   = hb;
      r.end_of_run = eor;
      expected_q.push_back(r);
    endfunction

    // Payload byte (have) or end of an empty frame; returns 1 when a result is due.
    function bit payload_step(bit have, logic [7:0] d, bit last);
      kind_e k;
      bit    streams;
      bit    eor;
      k       = KindText;
      streams = 1'b0;
      eor     = 1'b0;
      case (opcode)
        OpText: begin
          k       = fin ? KindText : KindFrag;
          streams = 1'b1;
          eor     = last && fin;
        end
        OpCont: begin
          k       = KindFrag;
          streams = (frag == FragText);
          eor     = last && fin && streams;
          if (last && fin) frag = FragNone;
        end
        OpPing: begin
          k       = KindPong;
          streams = 1'b1;
          eor     = last;
        end
        OpClose: begin
          k   = KindClose;
          eor = last;
        end
        default: ;
      endcase
      if (streams && have) begin
        push_result(k, d, 1'b1, eor);
        return 1'b1;
      end
      if (eor) begin
        push_result(k, 8'h00, 1'b0, 1'b1);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void finish_header();
      bit abandoned;
      abandoned = 1'b0;
      key_pos   = '0;
      if (!fin && (opcode == OpText || opcode == OpBin)) begin
        if (frag == FragText) begin
          push_result(KindAbandon, 8'h00, 1'b0, 1'b0);
          abandoned = 1'b1;
        end
        frag = (opcode == OpText) ? FragText : FragBin;
      end
      if (pay_left == 0) begin
        phase = PhFirst;
        if (!abandoned) void'(payload_step(1'b0, 8'h00, 1'b1));
      end else begin
        phase = PhPayload;
      end
    endfunction

    function void length_done();
      if (masked) begin
        phase    = PhKey;
        hdr_left = MaskBytes;
        key      = '0;
      end else begin
        finish_header();
      end
    endfunction

    function void note_byte(logic [7:0] b);
      bit         last;
      logic [7:0] v;
      bytes_seen++;
      case (phase)
        PhSecond: begin
          masked   = b[7];
          pay_left = '0;
          if (b[6:0] == Len7Ext16) begin
            phase    = PhExtLen;
            hdr_left = Ext16Bytes;
          end else if (b[6:0] == Len7Ext64) begin
            phase    = PhExtLen;
            hdr_left = Ext64Bytes;
          end else begin
            pay_left = 64'(b[6:0]);
            length_done();
          end
        end
        PhExtLen: begin
          if (pay_left > (LenMax >> 8)) begin
            pay_left = LenMax;
          end else begin
            pay_left = {pay_left[55:0], b};
            if (pay_left > LenMax) pay_left = LenMax;
          end
          hdr_left = hdr_left - 4'd1;
          if (hdr_left == 0) length_done();
        end
        PhKey: begin
          key      = {key[23:0], b};
          hdr_left = hdr_left - 4'd1;
          if (hdr_left == 0) finish_header();
        end
        PhPayload: begin
          last = (pay_left <= 1);
          v    = b;
          if (masked) v = b ^ key[8 * (3 - int'(key_pos)) +: 8];
          key_pos = key_pos + 2'd1;
          if (pay_left != 0) pay_left = pay_left - 64'd1;
          if (last) phase = PhFirst;
          void'(payload_step(1'b1, v, last));
        end
        default: begin
          fin    = b[7];
          opcode = b[3:0];
          phase  = PhSecond;
        end
      endcase
    endfunction

    function void report(string what);
      mismatches++;
      if (mismatches <= MaxReports) $display("[%0t] mismatch: %s", $time, what);
    endfunction

    function void check_result(wsd_result_t got);
      wsd_result_t want;
      results_seen++;
      if (got.kind <= KindClose) kind_seen[int'(got.kind)]++;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result kind %0d byte %02h has %0b end %0b",
                         got.kind, got.data, got.has_byte, got.end_of_run));
        return;
      end
      want = expected_q.pop_front();
      if (got.kind !== want.kind || got.data !== want.data ||
          got.has_byte !== want.has_byte || got.end_of_run !== want.end_of_run)
        report($sformatf("kind %0d/%0d byte %02h/%02h has %0b/%0b end %0b/%0b (exp/act)",
                         want.kind, got.kind, want.data, got.data, want.has_byte,
                         got.has_byte, want.end_of_run, got.end_of_run));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  wsd_rx_if  rx_ch ();
  wsd_res_if res_ch ();

  websocket_frame_deframer i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_ch),
    .res_o  (res_ch)
  );

  wsd_scoreboard sb = new();

  // Bytes waiting to go out on rx, and the byte count at which the sink
  // starts its long hold-off (armed by the stimulus once random traffic runs).
  logic [7:0]  rx_stream_q[$];
  int unsigned hold_trigger_at = '1;

  initial clk_i = 1'b0;
  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Watchdog: end the run if anything hangs.
  initial begin
    #(ClkPeriod * TimeoutCycles);
    $display("websocket_frame_deframer regression: fail");
    $finish;
  end

  // Monitor: sample both channels at the rising edge. Check the result beat
  // first; a byte accepted on this edge can only produce a later result.
  always @(posedge clk_i) begin : monitor
    wsd_result_t got;
    if (rst_ni) begin
      if (res_ch.valid && res_ch.ready) begin
        got.kind       = res_ch.out_kind;
        got.data       = res_ch.out_byte;
        got.has_byte   = res_ch.has_byte;
        got.end_of_run = res_ch.end_of_run;
        sb.check_result(got);
      end
      if (rx_ch.valid && rx_ch.ready) sb.note_byte(rx_ch.rx_byte);
    end
  end

  // Result sink: cycle through ready patterns of random length, and once,
  // while random traffic flows, hold ready low long enough to back up rx.
  initial begin : result_sink
    sink_mode_e  mode;
    int unsigned mode_left;
    int unsigned hold_left;
    bit          held_once;
    mode      = SinkOpen;
    mode_left = 0;
    hold_left = 0;
    held_once = 1'b0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held_once && sb.bytes_seen >= hold_trigger_at) begin
        held_once = 1'b1;
        hold_left = LongHoldCycles;
      end
      if (mode_left == 0) begin
        mode      = sink_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 80);
      end
      mode_left--;
      if (hold_left != 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        case (mode)
          SinkCoin:        res_ch.ready <= 1'($urandom_range(0, 1));
          SinkRare:        res_ch.ready <= ($urandom_range(0, 9) != 0);
          SinkEveryFourth: res_ch.ready <= (mode_left % 4 == 0);
          default:         res_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  // Append a frame header: FIN, random reserved bits, opcode, length in the
  // requested encoding and, for masked frames, the key.
  function automatic void add_header(bit fin, logic [3:0] op, bit masked,
                                     logic [63:0] len, len_form_e form,
                                     logic [31:0] key);
    rx_stream_q.push_back({fin, 3'($urandom_range(0, 7)), op});
    case (form)
      Form16: begin
        rx_stream_q.push_back({masked, Len7Ext16});
        rx_stream_q.push_back(len[15:8]);
        rx_stream_q.push_back(len[7:0]);
      end
      Form64: begin
        rx_stream_q.push_back({masked, Len7Ext64});
        for (int i = 7; i >= 0; i--) rx_stream_q.push_back(len[8 * i +: 8]);
      end
      default: rx_stream_q.push_back({masked, len[6:0]});
    endcase
    if (masked) for (int i = 3; i >= 0; i--) rx_stream_q.push_back(key[8 * i +: 8]);
  endfunction

  function automatic void add_payload(int unsigned n);
    repeat (n) rx_stream_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void add_frame(bit fin, logic [3:0] op, bit masked,
                                    int unsigned len, len_form_e form,
                                    logic [31:0] key);
    add_header(fin, op, masked, 64'(len), form, key);
    add_payload(len);
  endfunction

  // Random frame: mostly short payloads, now and then a longer one; the
  // length goes out in every encoding, non-minimal ones included.
  function automatic void add_rand_frame(bit fin, logic [3:0] op);
    int unsigned pick;
    int unsigned len;
    len_form_e   form;
    pick = $urandom_range(0, 99);
    len  = (pick < 10) ? 0 : (pick < 75) ? $urandom_range(1, 12) : $urandom_range(13, 40);
    pick = $urandom_range(0, 99);
    form = (pick < 80) ? FormShort : (pick < 92) ? Form16 : Form64;
    add_frame(fin, op, 1'($urandom_range(0, 1)), len, form, $urandom());
  endfunction

  // One random message. Most are well-formed; the rest abandon, interleave
  // or send stray continuations, and a few carry an arbitrary first byte.
  function automatic void add_random_message();
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(0, 99);
    if (pick < 28) begin
      add_rand_frame(1'b1, OpText);
    end else if (pick < 48) begin
      add_rand_frame(1'b0, OpText);
      n = $urandom_range(0, 3);
      repeat (n) begin
        if ($urandom_range(0, 3) == 0) add_rand_frame(1'b1, OpPing);
        add_rand_frame(1'b0, OpCont);
      end
      add_rand_frame(1'b1, OpCont);
    end else if (pick < 58) begin
      add_rand_frame(1'b1, OpPing);
    end else if (pick < 63) begin
      add_rand_frame(1'b1, OpClose);
    end else if (pick < 70) begin
      add_rand_frame(1'($urandom_range(0, 1)), OpBin);
      if ($urandom_range(0, 1) != 0) add_rand_frame(1'b1, OpCont);
    end else if (pick < 74) begin
      add_rand_frame(1'b1, OpPong);
    end else if (pick < 81) begin
      // Abandon: a second fragmented start lands on an open text fragment.
      add_rand_frame(1'b0, OpText);
      add_rand_frame(1'b0, ($urandom_range(0, 1) != 0) ? OpText : OpBin);
      add_rand_frame(1'b1, OpCont);
    end else if (pick < 86) begin
      // Complete text message nested in an open text fragment.
      add_rand_frame(1'b0, OpText);
      add_rand_frame(1'b1, OpText);
      add_rand_frame(1'b1, OpCont);
    end else if (pick < 92) begin
      add_rand_frame(1'($urandom_range(0, 1)), OpCont);
    end else begin
      add_rand_frame(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
    end
  endfunction

  // Offer the queued bytes in bursts of random length with random gaps.
  // Enter and leave at a falling edge.
  task automatic send_stream();
    int unsigned burst_left;
    int unsigned gap;
    burst_left = 0;
    while (rx_stream_q.size() != 0) begin
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                 : $urandom_range(1, 12);
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
          rx_ch.valid <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      rx_ch.valid   <= 1'b1;
      rx_ch.rx_byte <= rx_stream_q.pop_front();
      do @(posedge clk_i); while (!rx_ch.ready);
      @(negedge clk_i);
      burst_left--;
    end
    rx_ch.valid <= 1'b0;
  endtask

  // Hold the sender until every predicted result has been taken.
  task automatic wait_drained();
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned random_start;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = 8'h00;
    rst_ni        = 1'b0;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: text single frames, empty, masked with all-zero and all-one keys.
    add_frame(1'b1, OpText, 1'b0, 3, FormShort, 32'h0);
    add_frame(1'b1, OpText, 1'b0, 0, FormShort, 32'h0);
    add_frame(1'b1, OpText, 1'b1, 5, FormShort, 32'hFFFF_FFFF);
    add_frame(1'b1, OpText, 1'b1, 0, FormShort, 32'h0000_0000);
    // Fragmented text with an empty middle piece, then one that ends empty.
    add_frame(1'b0, OpText, 1'b1, 2, FormShort, $urandom());
    add_frame(1'b0, OpCont, 1'b0, 1, FormShort, 32'h0);
    add_frame(1'b0, OpCont, 1'b0, 0, FormShort, 32'h0);
    add_frame(1'b1, OpCont, 1'b1, 2, FormShort, $urandom());
    add_frame(1'b0, OpText, 1'b0, 1, FormShort, 32'h0);
    add_frame(1'b1, OpCont, 1'b0, 0, FormShort, 32'h0);
    // Complete text nested in an open fragment; the fragment stays open.
    add_frame(1'b0, OpText, 1'b0, 1, FormShort, 32'h0);
    add_frame(1'b1, OpText, 1'b0, 2, FormShort, 32'h0);
    add_frame(1'b1, OpCont, 1'b0, 1, FormShort, 32'h0);
    // Abandon twice: by a text start, then by an empty binary start.
    add_frame(1'b0, OpText, 1'b0, 2, FormShort, 32'h0);
    add_frame(1'b0, OpText, 1'b1, 1, FormShort, $urandom());
    add_frame(1'b0, OpBin, 1'b0, 0, FormShort, 32'h0);
    add_frame(1'b1, OpCont, 1'b0, 2, FormShort, 32'h0);
    // Stray continuations with nothing open.
    add_frame(1'b1, OpCont, 1'b0, 3, FormShort, 32'h0);
    add_frame(1'b0, OpCont, 1'b1, 1, FormShort, $urandom());
    // Binary, ping, pong, close (with and without payload), unknown opcodes.
    add_frame(1'b1, OpBin, 1'b1, 4, FormShort, $urandom());
    add_frame(1'b1, OpPing, 1'b1, 4, FormShort, $urandom());
    add_frame(1'b1, OpPing, 1'b0, 0, FormShort, 32'h0);
    add_frame(1'b1, OpPong, 1'b0, 3, FormShort, 32'h0);
    add_frame(1'b1, OpClose, 1'b1, 2, FormShort, $urandom());
    add_frame(1'b1, OpClose, 1'b0, 0, FormShort, 32'h0);
    add_frame(1'b1, 4'h3, 1'b0, 2, FormShort, 32'h0);
    add_frame(1'b0, 4'h7, 1'b1, 1, FormShort, $urandom());
    add_frame(1'b1, 4'hB, 1'b0, 1, FormShort, 32'h0);
    add_frame(1'b1, 4'hF, 1'b0, 0, FormShort, 32'h0);
    // Length encodings: largest short length, smallest natural 16-bit one,
    // and small values in the 16-bit and 64-bit forms.
    add_frame(1'b1, OpBin, 1'b0, 125, FormShort, 32'h0);
    add_frame(1'b1, OpText, 1'b1, 126, Form16, $urandom());
    add_frame(1'b1, OpText, 1'b0, 5, Form16, 32'h0);
    add_frame(1'b1, OpPing, 1'b0, 0, Form16, 32'h0);
    add_frame(1'b1, OpText, 1'b1, 3, Form64, $urandom());
    add_frame(1'b1, OpClose, 1'b0, 0, Form64, 32'h0);
    send_stream();
    wait_drained();

    // Random traffic in batches; drain between batches so the sender also
    // sits idle with nothing outstanding. Arm the long sink hold-off early
    // in the first batch so rx backs up while bytes are still offered.
    random_start    = sb.bytes_seen;
    hold_trigger_at = random_start + 40;
    while (sb.bytes_seen < random_start + RandomBytes) begin
      while (rx_stream_q.size() < BatchBytes) add_random_message();
      send_stream();
      wait_drained();
    end

    // Close with an all-ones 64-bit length: the ping never ends, so every
    // payload byte streams out without an end marker.
    add_header(1'b1, OpPing, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, Form64, $urandom());
    add_payload(TailBytes);
    send_stream();
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.expected_q.size()));
    $display("received %0d bytes, checked %0d results, %0d mismatches",
             sb.bytes_seen, sb.results_seen, sb.mismatches);
    $display("results by kind: text %0d, fragment %0d, abandon %0d, pong %0d, close %0d",
             sb.kind_seen[0], sb.kind_seen[1], sb.kind_seen[2], sb.kind_seen[3],
             sb.kind_seen[4]);
    if (sb.mismatches == 0) begin
      $display("websocket_frame_deframer regression: pass");
    end else begin
      $display("websocket_frame_deframer regression: fail");
    end
    $finish;
  end

endmodule
